FILE: rtl/core/smbg_pkg.sv
`default_nettype none
package smbg_pkg;
  localparam int unsigned DataW = 64;
  localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
  localparam logic CMD_RAW = 1'b0;
  localparam logic CMD_BOUNDED = 1'b1;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic        cmd;
    logic [6:0]  count;
    logic [63:0] bound;
    logic        bad;
  } req_t;
endpackage
`default_nettype wire

FILE: rtl/core/smbg_front.sv
`default_nettype none
module smbg_front import smbg_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         cmd,
  input  wire  [6:0]  bit_count,
  input  wire  [63:0] bound,
  output logic        q_valid,
  input  wire         q_ready,
  output req_t        q_data
);
  // Two-entry queue of classified requests.
  req_t       mem [2];
  logic       wp, rp;
  logic [1:0] fill;
  req_t       cls;
  logic       push, pop;

  // Classify: saturate the count, flag a zero bound on a bounded request.
  always_comb begin
    cls.cmd   = cmd;
    cls.count = (bit_count > 7'd64) ? 7'd64 : bit_count;
    cls.bound = bound;
    cls.bad   = (cmd == CMD_BOUNDED) && (bound == 64'd0);
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_data   = mem[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= cls;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/smbg_back.sv
`default_nettype none
module smbg_back import smbg_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         seed_we,
  input  wire  [63:0] seed,
  input  wire         q_valid,
  output logic        q_ready,
  input  req_t        q_data,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] value,
  output logic        bad_bound
);
  localparam logic [3:0] S_IDLE = 4'd0, S_TAKE = 4'd1, S_MIXA = 4'd2,
                         S_MIXB = 4'd3, S_MIXC = 4'd4, S_LIM = 4'd5,
                         S_DRAW = 4'd6, S_MOD = 4'd7, S_OUT = 4'd8;

  logic [3:0]  state;
  logic [63:0] gen, buffer, acc, z, bnd, limit;
  logic [6:0]  used, want, got;
  logic        is_bnd;
  // Restoring divider registers.
  logic [63:0] dv_rem, dv_num;
  logic [6:0]  dv_cnt;
  logic [64:0] dv_trial;
  logic [63:0] dv_sh;
  logic [6:0]  room, n;
  logic [63:0] mask, chunk;
  // Low half of a 64-bit product, built from three 32-bit partial products.
  logic [1:0]  mul_ph;
  logic [63:0] mul_acc, mul_k, mul_pp, mul_sum;
  logic [31:0] mul_x, mul_y;

  assign q_ready = (state == S_IDLE) && !out_valid;

  // Bits available in the buffer and chunk for this step, and the divider's trial subtraction.
  always_comb begin
    room  = 7'd64 - used;
    n     = ((want - got) > room) ? room : (want - got);
    mask  = (n >= 7'd64) ? '1 : ((64'd1 << n[5:0]) - 64'd1);
    chunk = (buffer >> used[5:0]) & mask;
    dv_sh = {dv_rem[62:0], dv_num[63]};
    dv_trial = {dv_rem[63], dv_sh} - {1'b0, bnd};
  end

  // One 32 by 32 partial product per cycle while no seed is written: low by low, then the two cross terms.
  always_comb begin
    mul_k = (state == S_MIXB) ? MIX_MUL_B : MIX_MUL_A;
    case (mul_ph)
      2'd0: begin
        mul_x = z[31:0];
        mul_y = mul_k[31:0];
      end
      2'd1: begin
        mul_x = z[31:0];
        mul_y = mul_k[63:32];
      end
      default: begin
        mul_x = z[63:32];
        mul_y = mul_k[31:0];
      end
    endcase
    mul_pp  = {32'd0, mul_x} * {32'd0, mul_y};
    mul_sum = mul_acc + {mul_pp[31:0], 32'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      gen <= 64'd0;
      buffer <= 64'd0;
      used <= 7'd64;
      mul_ph <= 2'd0;
    end else if (seed_we) begin
      gen <= seed;
      buffer <= 64'd0;
      used <= 7'd64;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            acc <= 64'd0;
            got <= 7'd0;
            bnd <= q_data.bound;
            bad_bound <= q_data.bad;
            is_bnd <= (q_data.cmd == CMD_BOUNDED);
            if (q_data.bad) begin
              value <= 64'd0;
              out_valid <= 1'b1;
            end else if (q_data.cmd == CMD_BOUNDED) begin
              want <= 7'd64;
              // limit = (2^64 - b) mod b
              dv_num <= 64'd0 - q_data.bound;
              dv_rem <= 64'd0;
              dv_cnt <= 7'd0;
              state <= S_LIM;
            end else begin
              want <= q_data.count;
              state <= S_TAKE;
            end
          end
        end
        S_LIM, S_MOD: begin
          // One quotient bit per cycle while no seed is written.
          dv_num <= {dv_num[62:0], 1'b0};
          if (!dv_trial[64]) dv_rem <= dv_trial[63:0];
          else dv_rem <= dv_sh;
          dv_cnt <= dv_cnt + 7'd1;
          if (dv_cnt == 7'd63) begin
            if (state == S_LIM) begin
              limit <= dv_trial[64] ? dv_sh : dv_trial[63:0];
              state <= S_TAKE;
            end else begin
              value <= dv_trial[64] ? dv_sh : dv_trial[63:0];
              state <= S_OUT;
            end
          end
        end
        S_TAKE: begin
          if (got == want) begin
            state <= is_bnd ? S_DRAW : S_OUT;
            if (!is_bnd) value <= acc;
          end else if (used >= 7'd64) begin
            gen <= gen + GOLDEN_INC;
            z <= (gen + GOLDEN_INC) ^ ((gen + GOLDEN_INC) >> 30);
            mul_ph <= 2'd0;
            state <= S_MIXA;
          end else begin
            acc <= acc | (chunk << got[5:0]);
            used <= used + n;
            got <= got + n;
          end
        end
        S_MIXA, S_MIXB: begin
          // Each multiply runs in three partial-product steps; the first mix step also folds in the 27-bit shift.
          case (mul_ph)
            2'd0: begin
              mul_acc <= mul_pp;
              mul_ph <= 2'd1;
            end
            2'd1: begin
              mul_acc <= mul_sum;
              mul_ph <= 2'd2;
            end
            default: begin
              mul_ph <= 2'd0;
              if (state == S_MIXA) begin
                z <= mul_sum ^ (mul_sum >> 27);
                state <= S_MIXB;
              end else begin
                z <= mul_sum;
                state <= S_MIXC;
              end
            end
          endcase
        end
        S_MIXC: begin
          buffer <= z ^ (z >> 31);
          used <= 7'd0;
          state <= S_TAKE;
        end
        S_DRAW: begin
          if (acc >= limit) begin
            dv_num <= acc;
            dv_rem <= 64'd0;
            dv_cnt <= 7'd0;
            state <= S_MOD;
          end else begin
            acc <= 64'd0;
            got <= 7'd0;
            state <= S_TAKE;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            bad_bound <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/splitmix_bit_stream_generator.sv
`default_nettype none
// Channel | Dir | Signals                  | tdata / tuser fields
// s_axis  | in  | tvalid tready tdata tuser| tdata: bit_count[6:0], bound[70:7]; tuser: cmd
// m_axis  | out | tvalid tready tdata tuser| tdata: value[63:0]; tuser: bad_bound
// seed    | in  | seed_we seed             | 64-bit seed
// The back end answers a raw request by taking chunks from the buffer, refilling it through
// the three mix steps when empty; a zero bound is answered straight from the idle state.
// A bounded request first computes the rejection limit, then draws 64-bit values until one
// is not below the limit, and returns its remainder modulo the bound.
// Reset (rst, synchronous) clears the queue and loads state zero with an empty buffer.
// A waiting result holds the back end; the two-entry queue takes requests until full.
module splitmix_bit_stream_generator import smbg_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         seed_we,
  input  wire  [63:0] seed,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [71:0] s_axis_tdata,  // bit_count[6:0], bound[70:7], zero pad
  input  wire         s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [63:0] m_axis_tdata,  // value
  output logic        m_axis_tuser   // bad_bound
);
  req_t q_data;
  logic q_valid, q_ready;
  logic unused_pad;
  assign unused_pad = s_axis_tdata[71];

  smbg_front u_front (
    .clk(clk), .rst(rst | seed_we), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .cmd(s_axis_tuser), .bit_count(s_axis_tdata[6:0]), .bound(s_axis_tdata[70:7]),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  smbg_back u_back (
    .clk(clk), .rst(rst), .seed_we(seed_we), .seed(seed),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .value(m_axis_tdata), .bad_bound(m_axis_tuser)
  );
endmodule
`default_nettype wire
